// ----- src/renc_pkg.sv -----
// ---------------------------------------------------------------------------
// Rotary encoder decoder package
// Payload types, register indexes, transition codes and widths shared by
// the decoder and its checker.
// ---------------------------------------------------------------------------
package renc_pkg;

  localparam int COUNT_WIDTH   = 16;
  localparam int TIMER_WIDTH   = 20;
  localparam int ROT_EL_WIDTH  = 9;
  localparam int ROT_LK_WIDTH  = 8;
  localparam int CFG_IDX_WIDTH = 2;

  // Register indexes of the configuration port
  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    REG_ROTATE_LOCKOUT = 2'd0,
    REG_PRESS_LOCKOUT  = 2'd1,
    REG_EVENT_PERIOD   = 2'd2
  } renc_reg_t;

  // 4-bit transition codes: previous (dt,clk) in 3:2, current in 1:0
  localparam logic [3:0] CODE_UP_A   = 4'h6;
  localparam logic [3:0] CODE_UP_B   = 4'h8;
  localparam logic [3:0] CODE_DOWN_A = 4'h2;
  localparam logic [3:0] CODE_DOWN_B = 4'hC;

  // Recorded direction: bit 4 marks an up step
  localparam logic [4:0] DIR_UP        = 5'h10;
  localparam logic [4:0] DIR_REV_DOWN  = {1'b0, CODE_DOWN_A};
  localparam logic [4:0] DIR_REV_UP    = {1'b1, CODE_UP_B};

  localparam logic [ROT_LK_WIDTH-1:0] ROTATE_LOCKOUT_RST = 8'd5;
  localparam logic [TIMER_WIDTH-1:0]  PRESS_LOCKOUT_RST  = 20'd500000;
  localparam logic [TIMER_WIDTH-1:0]  EVENT_PERIOD_RST   = 20'd400000;

  typedef struct packed {
    logic clk_level;
    logic dt_level;
    logic sw_level;
  } renc_in_t;

  typedef struct packed {
    logic                    press_event;
    logic                    rotate_event;
    logic signed [15:0]      rotate_count;
  } renc_out_t;

endpackage

// ----- src/rotary_encoder_event_decoder.sv -----
// ---------------------------------------------------------------------------
// Rotary encoder event decoder
// Debounces encoder clock/data and push switch samples, accumulates a net
// step count and reports pending press/rotate events once per period.
// ---------------------------------------------------------------------------
// Each input request is one microsecond sample of the pins, taken whole when
// accepted, so a new sample can be taken every cycle unless in_stall is high.
// All timers, the step counter and the event report update on accept;
// a report lands in the output register in the cycle after its sample.
// in_stall rises only while a report sits in the output register and the
// consumer stalls it; samples that cause no report still need the output
// register free only when they do cause one, but are held off the same way.
// Configuration writes are always taken (cfg_ready stays high).
module rotary_encoder_event_decoder
  import renc_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  renc_in_t                 in_data,
  output logic                     out_valid,
  input  logic                     out_stall,
  output renc_out_t                out_data,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_WIDTH-1:0] cfg_index,
  input  logic [TIMER_WIDTH-1:0]   cfg_data
);

  localparam logic [ROT_EL_WIDTH-1:0] ROT_EL_MAX = '1;
  localparam logic [TIMER_WIDTH-1:0]  TIMER_MAX  = '1;
  localparam logic signed [COUNT_WIDTH-1:0] CNT_MAX = {1'b0, {(COUNT_WIDTH-1){1'b1}}};
  localparam logic signed [COUNT_WIDTH-1:0] CNT_MIN = {1'b1, {(COUNT_WIDTH-1){1'b0}}};

  logic [ROT_LK_WIDTH-1:0]        rotate_lockout_r;
  logic [TIMER_WIDTH-1:0]         press_lockout_r;
  logic [TIMER_WIDTH-1:0]         event_period_r;

  logic [1:0]                     prev_pair_r,      prev_pair_nxt;
  logic [4:0]                     last_dir_r,       last_dir_nxt;
  logic signed [COUNT_WIDTH-1:0]  step_count_r,     step_count_nxt;
  logic                           pend_press_r,     pend_press_nxt;
  logic                           pend_rotate_r,    pend_rotate_nxt;
  logic [ROT_EL_WIDTH-1:0]        rot_el_r,         rot_el_nxt;
  logic [TIMER_WIDTH-1:0]         press_el_r,       press_el_nxt;
  logic [TIMER_WIDTH-1:0]         report_el_r,      report_el_nxt;
  logic                           last_clk_r;
  logic                           last_sw_r;
  logic                           out_valid_r,      out_valid_nxt;
  renc_out_t                      out_data_r,       out_data_nxt;

  logic                           accept;
  logic [ROT_EL_WIDTH-1:0]        rot_el_inc;
  logic [TIMER_WIDTH-1:0]         press_el_inc;
  logic [TIMER_WIDTH-1:0]         report_el_inc;
  logic [1:0]                     pair;
  logic [3:0]                     code;
  logic                           rot_take;
  logic                           step_up;
  logic                           step_down;

  assign in_stall  = out_valid_r & out_stall;
  assign accept    = in_valid & ~in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign pair = {in_data.dt_level, in_data.clk_level};
  assign code = {prev_pair_r, pair};

  always_comb begin
    rot_el_inc    = (rot_el_r == ROT_EL_MAX) ? ROT_EL_MAX : rot_el_r + 1'b1;
    press_el_inc  = (press_el_r == TIMER_MAX) ? TIMER_MAX : press_el_r + 1'b1;
    report_el_inc = (report_el_r == TIMER_MAX) ? TIMER_MAX : report_el_r + 1'b1;

    prev_pair_nxt   = prev_pair_r;
    last_dir_nxt    = last_dir_r;
    step_count_nxt  = step_count_r;
    pend_press_nxt  = pend_press_r;
    pend_rotate_nxt = pend_rotate_r;
    rot_el_nxt      = rot_el_inc;
    press_el_nxt    = press_el_inc;
    report_el_nxt   = report_el_inc;
    step_up         = 1'b0;
    step_down       = 1'b0;

    // clock edge outside the lockout window
    rot_take = (in_data.clk_level != last_clk_r) &&
               (rot_el_inc > {1'b0, rotate_lockout_r});
    if (rot_take) begin
      rot_el_nxt    = '0;
      prev_pair_nxt = pair;
      if (code == CODE_UP_A || code == CODE_UP_B) begin
        pend_rotate_nxt = 1'b1;
        if (last_dir_r == DIR_REV_DOWN) begin
          step_down    = 1'b1;
          last_dir_nxt = {1'b0, code};
        end else begin
          step_up      = 1'b1;
          last_dir_nxt = DIR_UP | {1'b0, code};
        end
      end else if (code == CODE_DOWN_A || code == CODE_DOWN_B) begin
        pend_rotate_nxt = 1'b1;
        if (last_dir_r == DIR_REV_UP) begin
          step_up      = 1'b1;
          last_dir_nxt = DIR_UP | {1'b0, code};
        end else begin
          step_down    = 1'b1;
          last_dir_nxt = {1'b0, code};
        end
      end
    end

    // saturate the count at its signed range
    if (step_up && step_count_r != CNT_MAX) begin
      step_count_nxt = step_count_r + 1'b1;
    end else if (step_down && step_count_r != CNT_MIN) begin
      step_count_nxt = step_count_r - 1'b1;
    end

    if (in_data.sw_level && !last_sw_r && (press_el_inc > press_lockout_r)) begin
      pend_press_nxt = 1'b1;
      press_el_nxt   = '0;
    end

    out_valid_nxt = out_valid_r & out_stall;
    out_data_nxt  = out_data_r;
    if (report_el_inc > event_period_r) begin
      report_el_nxt = '0;
      if (pend_press_nxt || pend_rotate_nxt) begin
        out_valid_nxt             = 1'b1;
        out_data_nxt.press_event  = pend_press_nxt;
        out_data_nxt.rotate_event = pend_rotate_nxt;
        out_data_nxt.rotate_count = pend_rotate_nxt ? step_count_nxt : '0;
        if (pend_rotate_nxt) begin
          step_count_nxt = '0;
        end
        pend_press_nxt  = 1'b0;
        pend_rotate_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rotate_lockout_r <= ROTATE_LOCKOUT_RST;
      press_lockout_r  <= PRESS_LOCKOUT_RST;
      event_period_r   <= EVENT_PERIOD_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (renc_reg_t'(cfg_index))
        REG_ROTATE_LOCKOUT: rotate_lockout_r <= cfg_data[ROT_LK_WIDTH-1:0];
        REG_PRESS_LOCKOUT:  press_lockout_r  <= cfg_data;
        REG_EVENT_PERIOD:   event_period_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_pair_r   <= '0;
      last_dir_r    <= '0;
      step_count_r  <= '0;
      pend_press_r  <= 1'b0;
      pend_rotate_r <= 1'b0;
      rot_el_r      <= '0;
      press_el_r    <= '0;
      report_el_r   <= '0;
      last_clk_r    <= 1'b0;
      last_sw_r     <= 1'b0;
      out_valid_r   <= 1'b0;
    end else if (accept) begin
      prev_pair_r   <= prev_pair_nxt;
      last_dir_r    <= last_dir_nxt;
      step_count_r  <= step_count_nxt;
      pend_press_r  <= pend_press_nxt;
      pend_rotate_r <= pend_rotate_nxt;
      rot_el_r      <= rot_el_nxt;
      press_el_r    <= press_el_nxt;
      report_el_r   <= report_el_nxt;
      last_clk_r    <= in_data.clk_level;
      last_sw_r     <= in_data.sw_level;
      out_valid_r   <= out_valid_nxt;
    end else begin
      // drop the report once the consumer takes it
      out_valid_r   <= out_valid_r & out_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule

// ----- src/renc_checker.sv -----
// ---------------------------------------------------------------------------
// Rotary encoder decoder checker
// Port-level checks on the event decoder, bound to its top level.
// ---------------------------------------------------------------------------
module renc_checker
  import renc_pkg::*;
(
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_stall,
  input logic                     out_valid,
  input logic                     out_stall,
  input renc_out_t                out_data
);

  // hold a stalled report
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled report changed or vanished");

  // a report always carries at least one event
  a_has_event: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.press_event || out_data.rotate_event))
    else $error("report without an event");

  a_count_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.rotate_event |-> out_data.rotate_count == '0)
    else $error("nonzero count without rotate event");

  // input is held off only behind a stalled report
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a pending report");

endmodule

bind rotary_encoder_event_decoder renc_checker u_renc_checker (.*);

// ----- test/tb_rotary_encoder_event_decoder.sv -----
// ---------------------------------------------------------------------------
// Rotary encoder event decoder testbench
// Drives pin samples and register writes into the decoder, predicts every
// event report with a cycle-free model of the decoder and checks each
// report field by field. A directed table comes first, then random
// quadrature, switch and noise traffic under several sender and receiver
// pacing modes.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_rotary_encoder_event_decoder;
  import renc_pkg::*;

  localparam logic [TIMER_WIDTH-1:0] TIMER_MAX = '1;

  typedef enum {BY_MODEL, NO_REPORT, GIVEN_REPORT} row_check_t;
  typedef enum {PACE_FREE, PACE_SEND_GAPS, PACE_RECV_STALLS, PACE_BOTH} pace_t;

  typedef struct {
    bit                     wr;
    renc_reg_t              idx;
    logic [TIMER_WIDTH-1:0] val;
    renc_in_t               smp;
    row_check_t             how;
    renc_out_t              rpt;
  } dir_row_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  renc_in_t                 in_data = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  renc_out_t                out_data;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CFG_IDX_WIDTH-1:0] cfg_index = '0;
  logic [TIMER_WIDTH-1:0]   cfg_data = '0;

  // Decoder model: registers and state
  logic [ROT_LK_WIDTH-1:0] rot_lockout = ROTATE_LOCKOUT_RST;
  logic [TIMER_WIDTH-1:0]  press_lockout = PRESS_LOCKOUT_RST;
  logic [TIMER_WIDTH-1:0]  report_period = EVENT_PERIOD_RST;
  logic [1:0]              last_pair = '0;
  logic [4:0]              last_turn = '0;
  logic signed [15:0]      net_steps = '0;
  bit                      press_pending = 1'b0;
  bit                      turn_pending = 1'b0;
  logic [ROT_EL_WIDTH-1:0] rot_age = '0;
  logic [TIMER_WIDTH-1:0]  press_age = '0;
  logic [TIMER_WIDTH-1:0]  report_age = '0;
  logic                    clk_seen = 1'b0;
  logic                    sw_seen = 1'b0;

  renc_out_t  reports_due[$];
  row_check_t row_how = BY_MODEL;
  renc_out_t  row_rpt = '0;
  int         gap_pct = 0;
  int         stall_pct = 0;
  int         flaws = 0;
  int         fed = 0;

  logic [1:0] gray [4] = '{2'b00, 2'b01, 2'b11, 2'b10};

  rotary_encoder_event_decoder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  function automatic void bump_steps(input int d);
    int v;
    v = int'(net_steps) + d;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    net_steps = 16'(v);
  endfunction

  // One microsecond tick: age the timers, then clock, switch and report
  function automatic bit decode_tick(input renc_in_t s, output renc_out_t rpt);
    logic [1:0] pair;
    logic [3:0] code;
    bit         fire;
    fire = 1'b0;
    rpt = '0;
    if (rot_age != '1) rot_age = rot_age + 1'b1;
    if (press_age != '1) press_age = press_age + 1'b1;
    if (report_age != '1) report_age = report_age + 1'b1;

    if (s.clk_level != clk_seen && rot_age > {1'b0, rot_lockout}) begin
      pair = {s.dt_level, s.clk_level};
      code = {last_pair, pair};
      if (code == CODE_UP_A || code == CODE_UP_B) begin
        if (last_turn == DIR_REV_DOWN) begin
          bump_steps(-1);
          last_turn = {1'b0, code};
        end else begin
          bump_steps(1);
          last_turn = DIR_UP | {1'b0, code};
        end
        turn_pending = 1'b1;
      end else if (code == CODE_DOWN_A || code == CODE_DOWN_B) begin
        if (last_turn == DIR_REV_UP) begin
          bump_steps(1);
          last_turn = DIR_UP | {1'b0, code};
        end else begin
          bump_steps(-1);
          last_turn = {1'b0, code};
        end
        turn_pending = 1'b1;
      end
      last_pair = pair;
      rot_age = '0;
    end
    clk_seen = s.clk_level;

    if (s.sw_level && !sw_seen && press_age > press_lockout) begin
      press_pending = 1'b1;
      press_age = '0;
    end
    sw_seen = s.sw_level;

    if (report_age > report_period) begin
      if (press_pending || turn_pending) begin
        rpt.press_event = press_pending;
        rpt.rotate_event = turn_pending;
        rpt.rotate_count = turn_pending ? net_steps : 16'sd0;
        fire = 1'b1;
        if (turn_pending) net_steps = '0;
        press_pending = 1'b0;
        turn_pending = 1'b0;
      end
      report_age = '0;
    end
    return fire;
  endfunction

  always @(posedge clk) begin : scoreboard
    renc_out_t rpt;
    renc_out_t want;
    bit        fired;
    if (rst_n && in_valid && !in_stall) begin
      fired = decode_tick(in_data, rpt);
      case (row_how)
        BY_MODEL:     if (fired) reports_due.push_back(rpt);
        GIVEN_REPORT: reports_due.push_back(row_rpt);
        default:      ;
      endcase
    end
    if (rst_n && out_valid && !out_stall) begin
      if (reports_due.size() == 0) begin
        $error("report with none pending: press %0b rotate %0b count %0d",
               out_data.press_event, out_data.rotate_event, out_data.rotate_count);
        flaws++;
      end else begin
        want = reports_due.pop_front();
        if (out_data.press_event !== want.press_event) begin
          $error("press_event: expected %0b, got %0b",
                 want.press_event, out_data.press_event);
          flaws++;
        end
        if (out_data.rotate_event !== want.rotate_event) begin
          $error("rotate_event: expected %0b, got %0b",
                 want.rotate_event, out_data.rotate_event);
          flaws++;
        end
        if (out_data.rotate_count !== want.rotate_count) begin
          $error("rotate_count: expected %0d, got %0d",
                 want.rotate_count, out_data.rotate_count);
          flaws++;
        end
      end
    end
  end

  function automatic void set_pace(input pace_t p);
    case (p)
      PACE_FREE:        begin gap_pct = 0;  stall_pct = 0;  end
      PACE_SEND_GAPS:   begin gap_pct = 53; stall_pct = 0;  end
      PACE_RECV_STALLS: begin gap_pct = 0;  stall_pct = 53; end
      default:          begin gap_pct = 10; stall_pct = 10; end
    endcase
  endfunction

  function automatic dir_row_t wr_row(input renc_reg_t idx, input logic [TIMER_WIDTH-1:0] val);
    dir_row_t r;
    r = '{default: '0, how: NO_REPORT, idx: idx};
    r.wr = 1'b1;
    r.val = val;
    return r;
  endfunction

  function automatic dir_row_t pin_row(input int c, input int d, input int s,
                                       input row_check_t how,
                                       input int pe, input int re, input int cnt);
    dir_row_t r;
    r = '{default: '0, how: how, idx: REG_ROTATE_LOCKOUT};
    r.smp = {1'(c), 1'(d), 1'(s)};
    r.rpt.press_event = 1'(pe);
    r.rpt.rotate_event = 1'(re);
    r.rpt.rotate_count = 16'(cnt);
    return r;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance
  task automatic send_sample(input renc_in_t s, input row_check_t how, input renc_out_t given);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= s;
    row_how = how;
    row_rpt = given;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic feed(input logic [1:0] dc, input bit sw);
    send_sample({dc[0], dc[1], sw}, BY_MODEL, '0);
    fed++;
  endtask

  // Hold the sender until every report has come, then let the pipe empty
  task automatic quiesce();
    in_valid <= 1'b0;
    while (reports_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  // Leaves cfg_valid high; the caller drops it
  task automatic write_reg(input renc_reg_t idx, input logic [TIMER_WIDTH-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_ROTATE_LOCKOUT: rot_lockout = val[ROT_LK_WIDTH-1:0];
      REG_PRESS_LOCKOUT:  press_lockout = val;
      REG_EVENT_PERIOD:   report_period = val;
      default:            ;
    endcase
    @(negedge clk);
  endtask

  task automatic program_regs(input logic [ROT_LK_WIDTH-1:0] rot,
                              input logic [TIMER_WIDTH-1:0] press,
                              input logic [TIMER_WIDTH-1:0] period);
    quiesce();
    write_reg(REG_ROTATE_LOCKOUT, TIMER_WIDTH'(rot));
    write_reg(REG_PRESS_LOCKOUT, press);
    write_reg(REG_EVENT_PERIOD, period);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    #3_000_000;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    dir_row_t   plan[$];
    int         hold;
    int         pick;
    logic [1:0] pos;
    logic [1:0] was;
    bit         up;
    bit         sw_now;
    bit         paused;

    pos = '0;
    sw_now = 1'b0;
    paused = 1'b0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Lockouts and period at zero: every tick reports whatever is pending
    plan.push_back(wr_row(REG_ROTATE_LOCKOUT, 20'd0));
    plan.push_back(wr_row(REG_PRESS_LOCKOUT, 20'd0));
    plan.push_back(wr_row(REG_EVENT_PERIOD, 20'd0));
    plan.push_back(pin_row(1, 0, 1, GIVEN_REPORT, 1, 0, 0));   // first samples
    plan.push_back(pin_row(0, 1, 0, BY_MODEL, 0, 0, 0));
    plan.push_back(pin_row(0, 1, 1, BY_MODEL, 0, 0, 0));
    plan.push_back(pin_row(0, 1, 1, BY_MODEL, 0, 0, 0));
    plan.push_back(pin_row(1, 1, 0, BY_MODEL, 0, 0, 0));
    plan.push_back(pin_row(0, 0, 0, BY_MODEL, 0, 0, 0));
    // Lockout of one: a clock change right after a taken one is dropped, which
    // lets the clock-steady codes through
    plan.push_back(wr_row(REG_ROTATE_LOCKOUT, 20'd1));
    plan.push_back(pin_row(1, 0, 0, BY_MODEL, 0, 0, 0));
    plan.push_back(pin_row(0, 1, 0, BY_MODEL, 0, 0, 0));
    plan.push_back(pin_row(1, 0, 0, BY_MODEL, 0, 0, 0));
    plan.push_back(pin_row(0, 0, 0, BY_MODEL, 0, 0, 0));  // reversed to down
    plan.push_back(pin_row(0, 0, 0, BY_MODEL, 0, 0, 0));
    plan.push_back(pin_row(1, 0, 0, BY_MODEL, 0, 0, 0));
    plan.push_back(pin_row(1, 0, 0, BY_MODEL, 0, 0, 0));
    plan.push_back(pin_row(0, 1, 0, BY_MODEL, 0, 0, 0));
    plan.push_back(pin_row(1, 1, 0, BY_MODEL, 0, 0, 0));
    plan.push_back(pin_row(0, 0, 0, BY_MODEL, 0, 0, 0));
    plan.push_back(pin_row(1, 1, 0, BY_MODEL, 0, 0, 0));
    plan.push_back(pin_row(0, 1, 0, BY_MODEL, 0, 0, 0));   // reversed to up
    // Register maximums: saturated press and report ages never exceed them
    plan.push_back(wr_row(REG_ROTATE_LOCKOUT, 20'd255));
    plan.push_back(wr_row(REG_PRESS_LOCKOUT, TIMER_MAX));
    plan.push_back(wr_row(REG_EVENT_PERIOD, TIMER_MAX));
    plan.push_back(pin_row(1, 1, 1, NO_REPORT, 0, 0, 0));
    plan.push_back(pin_row(0, 0, 0, NO_REPORT, 0, 0, 0));
    plan.push_back(pin_row(1, 0, 1, NO_REPORT, 0, 0, 0));

    set_pace(PACE_BOTH);
    foreach (plan[i]) begin
      if (plan[i].wr) begin
        quiesce();
        write_reg(plan[i].idx, plan[i].val);
        cfg_valid <= 1'b0;
      end else begin
        send_sample(plan[i].smp, plan[i].how, plan[i].rpt);
      end
    end

    for (int ph = 0; ph < 8; ph++) begin
      program_regs(ph == 5 ? 8'($urandom_range(100, 255)) : 8'($urandom_range(0, 6)),
                   ph == 6 ? 20'($urandom) : 20'($urandom_range(0, 30)),
                   ph == 3 ? 20'($urandom_range(150, 400)) : 20'($urandom_range(0, 20)));
      set_pace(pace_t'(ph % 4));
      fed = 0;
      while (fed < 236) begin
        if (ph == 2 && fed >= 118 && !paused) begin
          quiesce();
          paused = 1'b1;
        end
        pick = $urandom_range(99);
        if (pick < 65) begin
          // quadrature burst in one direction, each detent held 1 to lockout+2 samples
          up = $urandom_range(1);
          repeat ($urandom_range(1, 6)) begin
            was = pos;
            pos = up ? pos + 2'd1 : pos - 2'd1;
            if ($urandom_range(4) == 0) begin
              feed(gray[pos], sw_now);
              feed(gray[was], sw_now);
            end
            hold = $urandom_range(1, int'(rot_lockout) + 2);
            repeat (hold) feed(gray[pos], sw_now);
          end
        end else if (pick < 85) begin
          sw_now = ~sw_now;
          repeat ($urandom_range(1, 12)) feed(gray[pos], sw_now);
        end else begin
          repeat ($urandom_range(1, 4)) feed(2'($urandom), 1'($urandom));
        end
      end
    end

    quiesce();
    if (flaws == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
